// File: rtl/tphh_pkg.sv
// Shared types, constants and trig table for the track projection hit histogram.
`timescale 1ns / 1ps
`default_nettype none

package tphh_pkg;

	// Histogram geometry.
	localparam int X_BINS      = 15;
	localparam int Y_BINS      = 20;
	localparam int SLOPE_BINS  = 14;
	localparam int YSLOPE_BINS = 20;
	localparam int NCELLS      = X_BINS * Y_BINS * SLOPE_BINS;
	localparam int CELL_W      = $clog2(NCELLS);

	// Field widths.
	localparam int XB_W      = 4;
	localparam int YB_W      = 5;
	localparam int SB_W      = 4;
	localparam int CNT_W     = 32;
	localparam int OFS_W     = 21;
	localparam int SLOPE_W   = 17;
	localparam int REGION_W  = 3;
	localparam int PKG_W     = 3;
	localparam int OCT_W     = 4;
	localparam int DIST_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Only tracks of this region are histogrammed.
	localparam logic [REGION_W-1:0] TRACK_REGION = REGION_W'(3);

	// Arithmetic widths of the projection datapath.
	localparam int TRIG_W   = 18;
	localparam int OFS_SH   = 16;
	localparam int PROJ_W   = 40;
	localparam int POS_W    = 60;
	localparam int SLP_W    = 48;
	localparam int QW       = 20;
	localparam int POS_FRAC = 42;
	localparam int SLP_FRAC = 32;

	// x is binned by 2 cm, y by 10 cm = 5 * 2 cm; both start from a 2^43 shift.
	localparam int POS_SH = POS_FRAC + 1;
	localparam int Y_DIV  = 5;
	// y slope bins are 0.015 = 3 * 0.005; the fiducial limits on the scaled value are scaled by 3.
	localparam int YS_DIV = 3;

	// Reciprocal for the divide by five of the y quotient.
	localparam int Y_RSH   = 10;
	localparam int Y_RECIP = (1 << Y_RSH) / Y_DIV + 1;
	localparam int Y_T_W   = $clog2(Y_DIV * Y_BINS);

	// Bin edges in the scaled fixed-point formats.
	localparam logic signed [POS_W-1:0] X_EDGE   = POS_W'(320) <<< POS_FRAC;
	localparam logic signed [POS_W-1:0] Y_EDGE   = POS_W'(100) <<< POS_FRAC;
	localparam logic signed [SLP_W-1:0] SX_SCALE = SLP_W'(100);
	localparam logic signed [SLP_W-1:0] SX_EDGE  = SLP_W'(34) <<< SLP_FRAC;
	localparam logic signed [SLP_W-1:0] SY_SCALE = SLP_W'(200);
	localparam logic signed [SLP_W-1:0] SY_EDGE  = SLP_W'(30) <<< SLP_FRAC;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PACKAGE = 2'd0,
		CFG_OCTANT  = 2'd1,
		CFG_PLANE   = 2'd2
	} cfg_reg_t;

	// States of the histogram back end.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RMW
	} back_state_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic            accepted;
		logic            in_range;
		logic [XB_W-1:0] x_bin;
		logic [YB_W-1:0] y_bin;
		logic [SB_W-1:0] slope_bin;
	} qentry_t;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(65536);
	localparam logic signed [TRIG_W-1:0] TRIG_R2   = TRIG_W'(46341);
	localparam logic signed [TRIG_W-1:0] TRIG_ZERO = TRIG_W'(0);

	// Cosine of minus 45 degrees times k, Q1.16.
	function automatic logic signed [TRIG_W-1:0] cos_q(input logic [2:0] k);
		logic signed [TRIG_W-1:0] r;
		unique case (k)
			3'd0: r = TRIG_ONE;
			3'd1: r = TRIG_R2;
			3'd2: r = TRIG_ZERO;
			3'd3: r = -TRIG_R2;
			3'd4: r = -TRIG_ONE;
			3'd5: r = -TRIG_R2;
			3'd6: r = TRIG_ZERO;
			default: r = TRIG_R2;
		endcase
		return r;
	endfunction

	// Sine of minus 45 degrees times k, Q1.16.
	function automatic logic signed [TRIG_W-1:0] sin_q(input logic [2:0] k);
		logic signed [TRIG_W-1:0] r;
		unique case (k)
			3'd0: r = TRIG_ZERO;
			3'd1: r = -TRIG_R2;
			3'd2: r = -TRIG_ONE;
			3'd3: r = -TRIG_R2;
			3'd4: r = TRIG_ZERO;
			3'd5: r = TRIG_R2;
			3'd6: r = TRIG_ONE;
			default: r = TRIG_R2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/track_projection_hit_histogram_top.sv
// Top level of the track projection hit histogram: configuration registers and wiring.
// A word accepted at in_valid passes five front stages and the queue, then is read and, for
// an accepted track, updated in the back before it shows on out_valid; stalls can hold it.
// The back reads and then updates the histogram port for one word before it takes the next.
// Reset: counters and configuration take their reset values; the 4200 histogram cells are then
// cleared one cell a cycle, during which in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module track_projection_hit_histogram_top #(
	parameter int QUEUE_DEPTH = tphh_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tphh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tphh_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic signed [tphh_pkg::OFS_W-1:0]   x_offset,
	input  wire logic signed [tphh_pkg::OFS_W-1:0]   y_offset,
	input  wire logic signed [tphh_pkg::SLOPE_W-1:0] x_slope,
	input  wire logic signed [tphh_pkg::SLOPE_W-1:0] y_slope,
	input  wire logic [tphh_pkg::REGION_W-1:0]       region,
	input  wire logic [tphh_pkg::PKG_W-1:0]          package_req,
	input  wire logic [tphh_pkg::XB_W-1:0]           read_x_bin,
	input  wire logic [tphh_pkg::YB_W-1:0]           read_y_bin,
	input  wire logic [tphh_pkg::SB_W-1:0]           read_slope_bin,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     accepted,
	output logic                                     in_range,
	output logic [tphh_pkg::XB_W-1:0]                x_bin,
	output logic [tphh_pkg::YB_W-1:0]                y_bin,
	output logic [tphh_pkg::SB_W-1:0]                slope_bin,
	output logic [tphh_pkg::CNT_W-1:0]               bin_count,
	output logic [tphh_pkg::CNT_W-1:0]               tracks_used,
	output logic [tphh_pkg::CNT_W-1:0]               off_fiducial
);
	import tphh_pkg::*;

	logic [PKG_W-1:0]  package_select_q;
	logic [OCT_W-1:0]  octant_q;
	logic [DIST_W-1:0] plane_distance_q;
	logic              clear_busy, queue_full, queue_not_empty, q_push, q_pop;
	qentry_t           push_entry, head_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			package_select_q <= PKG_W'(1);
			octant_q         <= OCT_W'(1);
			plane_distance_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PACKAGE: package_select_q <= cfg_data[PKG_W-1:0];
				CFG_OCTANT:  octant_q         <= cfg_data[OCT_W-1:0];
				CFG_PLANE:   plane_distance_q <= cfg_data[DIST_W-1:0];
				default:     plane_distance_q <= plane_distance_q;
			endcase
		end
	end

	tphh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.x_offset       (x_offset),
		.y_offset       (y_offset),
		.x_slope        (x_slope),
		.y_slope        (y_slope),
		.region         (region),
		.package_req    (package_req),
		.read_x_bin     (read_x_bin),
		.read_y_bin     (read_y_bin),
		.read_slope_bin (read_slope_bin),
		.package_select (package_select_q),
		.octant         (octant_q),
		.plane_distance (plane_distance_q),
		.clear_busy     (clear_busy),
		.queue_full     (queue_full),
		.q_push         (q_push),
		.q_entry        (push_entry)
	);

	tphh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head_entry),
		.not_empty  (queue_not_empty),
		.full       (queue_full)
	);

	tphh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (queue_not_empty),
		.q_head       (head_entry),
		.q_pop        (q_pop),
		.clear_busy   (clear_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.in_range     (in_range),
		.x_bin        (x_bin),
		.y_bin        (y_bin),
		.slope_bin    (slope_bin),
		.bin_count    (bin_count),
		.tracks_used  (tracks_used),
		.off_fiducial (off_fiducial)
	);

endmodule

`default_nettype wire

// File: rtl/tphh_front.sv
// Front end: accepts words, projects, rotates and bins tracks into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module tphh_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic signed [tphh_pkg::OFS_W-1:0]   x_offset,
	input  wire logic signed [tphh_pkg::OFS_W-1:0]   y_offset,
	input  wire logic signed [tphh_pkg::SLOPE_W-1:0] x_slope,
	input  wire logic signed [tphh_pkg::SLOPE_W-1:0] y_slope,
	input  wire logic [tphh_pkg::REGION_W-1:0]       region,
	input  wire logic [tphh_pkg::PKG_W-1:0]          package_req,
	input  wire logic [tphh_pkg::XB_W-1:0]           read_x_bin,
	input  wire logic [tphh_pkg::YB_W-1:0]           read_y_bin,
	input  wire logic [tphh_pkg::SB_W-1:0]           read_slope_bin,
	input  wire logic [tphh_pkg::PKG_W-1:0]          package_select,
	input  wire logic [tphh_pkg::OCT_W-1:0]          octant,
	input  wire logic [tphh_pkg::DIST_W-1:0]         plane_distance,
	input  wire logic                                clear_busy,
	input  wire logic                                queue_full,
	output logic                                     q_push,
	output tphh_pkg::qentry_t                        q_entry
);
	import tphh_pkg::*;

	// Control information that travels alongside the arithmetic.
	typedef struct packed {
		logic            is_read;
		logic            acc;
		logic [XB_W-1:0] rx;
		logic [YB_W-1:0] ry;
		logic [SB_W-1:0] rs;
	} tag_t;

	localparam logic signed [POS_W-1:0] POS_RND  = (POS_W'(1) <<< POS_SH) - POS_W'(1);
	localparam logic signed [POS_W-1:0] POS_ZERO = '0;
	localparam logic signed [SLP_W-1:0] SLP_RND  = (SLP_W'(1) <<< SLP_FRAC) - SLP_W'(1);
	localparam logic signed [SLP_W-1:0] SLP_ZERO = '0;
	localparam logic signed [QW-1:0]    Q_ZERO   = '0;
	localparam logic signed [QW-1:0]    QX_LIM   = QW'(X_BINS);
	localparam logic signed [QW-1:0]    QY_LO    = QW'(-(Y_DIV - 1));
	localparam logic signed [QW-1:0]    QY_LIM   = QW'(Y_DIV * Y_BINS);
	localparam logic signed [QW-1:0]    QSX_LIM  = QW'(SLOPE_BINS);
	localparam logic signed [QW-1:0]    QSY_LO   = QW'(-(YS_DIV - 1));
	localparam logic signed [QW-1:0]    QSY_LIM  = QW'(YS_DIV * YSLOPE_BINS);
	localparam int                      YP_W     = Y_T_W + Y_RSH;

	logic adv, accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t tag_c, tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [2:0]                  k_c;
	logic signed [PROJ_W-1:0]    xp_c, yp_c;
	logic signed [PROJ_W-1:0]    xp_s1, yp_s1;
	logic signed [SLOPE_W-1:0]   xs_s1, ys_s1;
	logic signed [TRIG_W-1:0]    c_s1, s_s1;
	logic signed [POS_W-1:0]     pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [SLP_W-1:0]     sxc_s2, sys_s2, sxs_s2, syc_s2;
	logic signed [POS_W-1:0]     xl_s3, yl_s3;
	logic signed [SLP_W-1:0]     xsl_s3, ysl_s3;
	logic signed [POS_W-1:0]     nx_s4, ny_s4;
	logic signed [SLP_W-1:0]     sx_s4, sy_s4;
	logic signed [POS_W-1:0]     nx_r, ny_r;
	logic signed [SLP_W-1:0]     sx_r, sy_r;
	logic signed [QW-1:0]        qx_s5, qy_s5, qsx_s5, qsy_s5;
	logic                        fid;
	logic [YP_W-1:0]             iy_prod;
	logic [YB_W-1:0]             iy;

	// The whole pipeline holds when its last word cannot enter the queue.
	assign adv      = !(v_s5 && queue_full);
	assign in_stall = clear_busy || !adv;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s5 && !queue_full;

	// Classification of the incoming word.
	assign tag_c.is_read = func;
	assign tag_c.acc     = !func && (region == TRACK_REGION) && (package_req == package_select);
	assign tag_c.rx      = read_x_bin;
	assign tag_c.ry      = read_y_bin;
	assign tag_c.rs      = read_slope_bin;

	// Projection to the plane, in 2^-26 cm.
	assign k_c  = octant[2:0] - 3'd1;
	assign xp_c = PROJ_W'($signed({x_offset, {OFS_SH{1'b0}}}))
		+ PROJ_W'(x_slope) * PROJ_W'($signed({1'b0, plane_distance}));
	assign yp_c = PROJ_W'($signed({y_offset, {OFS_SH{1'b0}}}))
		+ PROJ_W'(y_slope) * PROJ_W'($signed({1'b0, plane_distance}));

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Truncation toward zero: negative values are biased before the shift.
	assign nx_r = nx_s4 + (nx_s4[POS_W-1] ? POS_RND : POS_ZERO);
	assign ny_r = ny_s4 + (ny_s4[POS_W-1] ? POS_RND : POS_ZERO);
	assign sx_r = sx_s4 + (sx_s4[SLP_W-1] ? SLP_RND : SLP_ZERO);
	assign sy_r = sy_s4 + (sy_s4[SLP_W-1] ? SLP_RND : SLP_ZERO);

	// Datapath stages: inputs and trig values, rotate products, sums, offsets and scaling, quotients.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_c;
			xp_s1  <= xp_c;
			yp_s1  <= yp_c;
			xs_s1  <= x_slope;
			ys_s1  <= y_slope;
			c_s1   <= cos_q(k_c);
			s_s1   <= sin_q(k_c);

			tag_s2 <= tag_s1;
			pxc_s2 <= POS_W'(xp_s1) * POS_W'(c_s1);
			pys_s2 <= POS_W'(yp_s1) * POS_W'(s_s1);
			pxs_s2 <= POS_W'(xp_s1) * POS_W'(s_s1);
			pyc_s2 <= POS_W'(yp_s1) * POS_W'(c_s1);
			sxc_s2 <= SLP_W'(xs_s1) * SLP_W'(c_s1);
			sys_s2 <= SLP_W'(ys_s1) * SLP_W'(s_s1);
			sxs_s2 <= SLP_W'(xs_s1) * SLP_W'(s_s1);
			syc_s2 <= SLP_W'(ys_s1) * SLP_W'(c_s1);

			tag_s3 <= tag_s2;
			xl_s3  <= pxc_s2 - pys_s2;
			yl_s3  <= pxs_s2 + pyc_s2;
			xsl_s3 <= sxc_s2 - sys_s2;
			ysl_s3 <= sxs_s2 + syc_s2;

			tag_s4 <= tag_s3;
			nx_s4  <= xl_s3 - X_EDGE;
			ny_s4  <= yl_s3 + Y_EDGE;
			sx_s4  <= xsl_s3 * SX_SCALE - SX_EDGE;
			sy_s4  <= ysl_s3 * SY_SCALE + SY_EDGE;

			tag_s5 <= tag_s4;
			qx_s5  <= $signed(nx_r[POS_SH +: QW]);
			qy_s5  <= $signed(ny_r[POS_SH +: QW]);
			qsx_s5 <= $signed(sx_r[SLP_FRAC +: QW]);
			qsy_s5 <= $signed(sy_r[SLP_FRAC +: QW]);
		end
	end

	// Fiducial check; the y and y slope quotients still carry a factor of 5 and 3.
	assign fid = (qx_s5 >= Q_ZERO) && (qx_s5 < QX_LIM)
		&& (qy_s5 >= QY_LO) && (qy_s5 < QY_LIM)
		&& (qsx_s5 >= Q_ZERO) && (qsx_s5 < QSX_LIM)
		&& (qsy_s5 >= QSY_LO) && (qsy_s5 < QSY_LIM);

	// Divide the y quotient by five with a reciprocal; small negatives give bin zero.
	assign iy_prod = YP_W'(qy_s5[Y_T_W-1:0]) * YP_W'(Y_RECIP);
	assign iy      = qy_s5[QW-1] ? '0 : iy_prod[Y_RSH +: YB_W];

	// Entry for the back end.
	always_comb begin
		q_entry = '0;
		if (tag_s5.is_read) begin
			q_entry.in_range  = (int'(tag_s5.rx) < X_BINS) && (int'(tag_s5.ry) < Y_BINS)
				&& (int'(tag_s5.rs) < SLOPE_BINS);
			q_entry.x_bin     = tag_s5.rx;
			q_entry.y_bin     = tag_s5.ry;
			q_entry.slope_bin = tag_s5.rs;
		end else if (tag_s5.acc) begin
			q_entry.accepted = 1'b1;
			q_entry.in_range = fid;
			if (fid) begin
				q_entry.x_bin     = qx_s5[XB_W-1:0];
				q_entry.y_bin     = iy;
				q_entry.slope_bin = qsx_s5[SB_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/tphh_queue.sv
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module tphh_queue #(
	parameter int DEPTH = tphh_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  tphh_pkg::qentry_t      push_entry,
	input  wire logic              pop,
	output tphh_pkg::qentry_t      head,
	output logic                   not_empty,
	output logic                   full
);
	import tphh_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BW = $clog2(DEPTH + 1);

	qentry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_BW-1:0]   count_q;

	assign full      = (count_q == CNT_BW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/tphh_back.sv
// Back end: histogram memory with clearing pass, read-modify-write and counters.
`timescale 1ns / 1ps
`default_nettype none

module tphh_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_not_empty,
	input  tphh_pkg::qentry_t                    q_head,
	output logic                                 q_pop,
	output logic                                 clear_busy,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 accepted,
	output logic                                 in_range,
	output logic [tphh_pkg::XB_W-1:0]            x_bin,
	output logic [tphh_pkg::YB_W-1:0]            y_bin,
	output logic [tphh_pkg::SB_W-1:0]            slope_bin,
	output logic [tphh_pkg::CNT_W-1:0]           bin_count,
	output logic [tphh_pkg::CNT_W-1:0]           tracks_used,
	output logic [tphh_pkg::CNT_W-1:0]           off_fiducial
);
	import tphh_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	back_state_t          state_q, state_d;
	logic [CELL_W-1:0]    clr_addr_q;
	logic [CELL_W-1:0]    cell_addr;
	logic [CNT_W-1:0]     hist_mem [NCELLS];
	logic [CNT_W-1:0]     rdata_q;
	logic [CNT_W-1:0]     used_q, outside_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 rd_en, mem_we, load_out;
	logic [CELL_W-1:0]    mem_waddr;
	logic [CNT_W-1:0]     mem_wdata;
	logic [CNT_W-1:0]     inc_val, count_d;

	assign out_free   = !out_valid_q || !out_stall;
	assign clear_busy = (state_q == BK_CLEAR);
	assign out_valid  = out_valid_q;

	// Cell address of the head word; only meaningful when it lies inside the bins.
	assign cell_addr = q_head.in_range
		? CELL_W'(int'(q_head.x_bin) * (Y_BINS * SLOPE_BINS)
			+ int'(q_head.y_bin) * SLOPE_BINS + int'(q_head.slope_bin))
		: '0;

	assign inc_val = sat_inc(rdata_q);

	// Histogram memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= hist_mem[cell_addr];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_addr_q == CELL_W'(NCELLS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_not_empty) begin
					state_d = BK_RMW;
				end
			end
			BK_RMW: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	// State outputs: memory port, queue pop and result load.
	always_comb begin
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cell_addr;
		mem_wdata = inc_val;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			BK_IDLE: begin
				rd_en = q_not_empty;
			end
			BK_RMW: begin
				if (out_free) begin
					q_pop    = 1'b1;
					load_out = 1'b1;
					mem_we   = q_head.accepted && q_head.in_range;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Bin content reported with the result.
	always_comb begin
		if (q_head.accepted && q_head.in_range) begin
			count_d = inc_val;
		end else if (q_head.in_range) begin
			count_d = rdata_q;
		end else begin
			count_d = '0;
		end
	end

	// Control state, counters and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			used_q      <= '0;
			outside_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (q_head.accepted) begin
					used_q <= sat_inc(used_q);
					if (!q_head.in_range) begin
						outside_q <= sat_inc(outside_q);
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted  <= q_head.accepted;
			in_range  <= q_head.in_range;
			x_bin     <= q_head.x_bin;
			y_bin     <= q_head.y_bin;
			slope_bin <= q_head.slope_bin;
			bin_count <= count_d;
		end
	end

	assign tracks_used  = used_q;
	assign off_fiducial = outside_q;

endmodule

`default_nettype wire

// File: tb/track_projection_hit_histogram_top_tb.sv
// Self-checking testbench for the track projection hit histogram top level.
`timescale 1ns / 1ps

module track_projection_hit_histogram_top_tb;
	import tphh_pkg::*;

	// One input word as the testbench builds it.
	typedef struct packed {
		bit               func;
		bit [OFS_W-1:0]   x_off;
		bit [OFS_W-1:0]   y_off;
		bit [SLOPE_W-1:0] xs;
		bit [SLOPE_W-1:0] ys;
		bit [REGION_W-1:0] region;
		bit [PKG_W-1:0]   pkg;
		bit [XB_W-1:0]    rx;
		bit [YB_W-1:0]    ry;
		bit [SB_W-1:0]    rs;
	} track_word_t;

	// One expected result word.
	typedef struct packed {
		bit             accepted;
		bit             in_range;
		bit [XB_W-1:0]  xb;
		bit [YB_W-1:0]  yb;
		bit [SB_W-1:0]  sb;
		bit [CNT_W-1:0] cnt;
		bit [CNT_W-1:0] used;
		bit [CNT_W-1:0] outside;
	} hit_result_t;

	// Fixed-point units: positions after rotation in 2^-42 cm, slopes in 2^-32.
	localparam longint CM_UNIT    = longint'(1) << 42;
	localparam longint SLOPE_UNIT = longint'(1) << 32;

	// Block ports.
	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DAT_W-1:0]  cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic                  func           = 1'b0;
	logic signed [OFS_W-1:0]   x_offset   = '0;
	logic signed [OFS_W-1:0]   y_offset   = '0;
	logic signed [SLOPE_W-1:0] x_slope    = '0;
	logic signed [SLOPE_W-1:0] y_slope    = '0;
	logic [REGION_W-1:0]   region         = '0;
	logic [PKG_W-1:0]      package_req    = '0;
	logic [XB_W-1:0]       read_x_bin     = '0;
	logic [YB_W-1:0]       read_y_bin     = '0;
	logic [SB_W-1:0]       read_slope_bin = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic                  accepted;
	logic                  in_range;
	logic [XB_W-1:0]       x_bin;
	logic [YB_W-1:0]       y_bin;
	logic [SB_W-1:0]       slope_bin;
	logic [CNT_W-1:0]      bin_count;
	logic [CNT_W-1:0]      tracks_used;
	logic [CNT_W-1:0]      off_fiducial;

	// Rotation table, Q1.16, for minus 45 degrees per octant step.
	longint rot_cos [0:7] = '{65536, 46341, 0, -46341, -65536, -46341, 0, 46341};
	longint rot_sin [0:7] = '{0, -46341, -65536, -46341, 0, 46341, 65536, 46341};

	// Shadow of the configuration and of the histogram state.
	bit [PKG_W-1:0]  sel_package = 1;
	bit [OCT_W-1:0]  sel_octant  = 1;
	bit [DIST_W-1:0] plane_dz    = 0;
	bit [CNT_W-1:0]  hist_cells [0:NCELLS-1];
	bit [CNT_W-1:0]  used_tracks    = 0;
	bit [CNT_W-1:0]  outside_tracks = 0;

	hit_result_t expected_results [$];
	int          hit_cells [$];

	int idle_pct   = 30;
	int n_errors   = 0;
	int n_words    = 0;
	int n_kept     = 0;
	int n_binned   = 0;
	int n_off      = 0;
	int n_reads    = 0;
	int n_settings = 0;

	track_projection_hit_histogram_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.x_offset      (x_offset),
		.y_offset      (y_offset),
		.x_slope       (x_slope),
		.y_slope       (y_slope),
		.region        (region),
		.package_req   (package_req),
		.read_x_bin    (read_x_bin),
		.read_y_bin    (read_y_bin),
		.read_slope_bin(read_slope_bin),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.in_range      (in_range),
		.x_bin         (x_bin),
		.y_bin         (y_bin),
		.slope_bin     (slope_bin),
		.bin_count     (bin_count),
		.tracks_used   (tracks_used),
		.off_fiducial  (off_fiducial)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic bit [CNT_W-1:0] sat_inc(input bit [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Model one word: read a bin, or project, rotate and bin a track and update the shadow histogram.
	function automatic hit_result_t project_and_bin(input track_word_t w);
		hit_result_t r;
		longint xo, yo, xs, ys, dz, c, sn, xp, yp, xl, yl, xsl, ysl, ix, iy, isx, isy;
		int cell_idx;
		bit [2:0] k;
		r = '0;
		if (w.func) begin
			n_reads++;
			r.xb = w.rx;
			r.yb = w.ry;
			r.sb = w.rs;
			if (w.rx < X_BINS && w.ry < Y_BINS && w.rs < SLOPE_BINS) begin
				cell_idx = (int'(w.rx) * Y_BINS + int'(w.ry)) * SLOPE_BINS + int'(w.rs);
				r.in_range = 1'b1;
				r.cnt = hist_cells[cell_idx];
			end
		end else if (w.region == TRACK_REGION && w.pkg == sel_package) begin
			k   = 3'(sel_octant - 4'd1);
			c   = rot_cos[k];
			sn  = rot_sin[k];
			xo  = $signed(w.x_off);
			yo  = $signed(w.y_off);
			xs  = $signed(w.xs);
			ys  = $signed(w.ys);
			dz  = plane_dz;
			xp  = xo * 65536 + xs * dz;
			yp  = yo * 65536 + ys * dz;
			xl  = xp * c - yp * sn;
			yl  = xp * sn + yp * c;
			xsl = xs * c - ys * sn;
			ysl = xs * sn + ys * c;
			// Integer division truncates toward zero, so (-1,0) lands in bin 0.
			ix  = (xl - 320 * CM_UNIT) / (2 * CM_UNIT);
			iy  = (yl + 100 * CM_UNIT) / (10 * CM_UNIT);
			isx = (xsl * 1000 - 340 * SLOPE_UNIT) / (10 * SLOPE_UNIT);
			isy = (ysl * 1000 + 150 * SLOPE_UNIT) / (15 * SLOPE_UNIT);
			r.accepted  = 1'b1;
			used_tracks = sat_inc(used_tracks);
			n_kept++;
			if (ix >= 0 && ix < X_BINS && iy >= 0 && iy < Y_BINS &&
			    isx >= 0 && isx < SLOPE_BINS && isy >= 0 && isy < YSLOPE_BINS) begin
				cell_idx = (int'(ix) * Y_BINS + int'(iy)) * SLOPE_BINS + int'(isx);
				hist_cells[cell_idx] = sat_inc(hist_cells[cell_idx]);
				hit_cells.push_back(cell_idx);
				r.in_range = 1'b1;
				r.xb  = XB_W'(ix);
				r.yb  = YB_W'(iy);
				r.sb  = SB_W'(isx);
				r.cnt = hist_cells[cell_idx];
				n_binned++;
			end else begin
				outside_tracks = sat_inc(outside_tracks);
				n_off++;
			end
		end
		r.used    = used_tracks;
		r.outside = outside_tracks;
		return r;
	endfunction

	// Word with every field random: noise tracks and reads alike.
	function automatic track_word_t random_word();
		track_word_t w;
		w.func   = 1'($urandom);
		w.x_off  = OFS_W'($urandom);
		w.y_off  = OFS_W'($urandom);
		w.xs     = SLOPE_W'($urandom);
		w.ys     = SLOPE_W'($urandom);
		w.region = REGION_W'($urandom);
		w.pkg    = PKG_W'($urandom);
		w.rx     = XB_W'($urandom);
		w.ry     = YB_W'($urandom);
		w.rs     = SB_W'($urandom);
		return w;
	endfunction

	// Track of the kept region and package whose local position and slopes land near or
	// inside the fiducial bins; the global values come from the transposed rotation.
	function automatic track_word_t aimed_track();
		track_word_t w;
		longint c, sn, dz, lx, ly, lxs, lys, gx, gy, gxs, gys;
		bit [2:0] k;
		w        = random_word();
		w.func   = 1'b0;
		w.region = TRACK_REGION;
		w.pkg    = sel_package;
		k   = 3'(sel_octant - 4'd1);
		c   = rot_cos[k];
		sn  = rot_sin[k];
		dz  = plane_dz;
		// Targets reach past each edge, by about one bin in the slopes and by 1 cm in the positions.
		lx  = longint'($urandom_range(359423, 326656));
		ly  = longint'($urandom_range(206847, 0)) - 103424;
		lxs = longint'($urandom_range(32112, 21627));
		lys = longint'($urandom_range(21626, 0)) - 10813;
		gxs = (lxs * c + lys * sn) / 65536;
		gys = (lys * c - lxs * sn) / 65536;
		gx  = (lx * c + ly * sn) / 65536;
		gy  = (ly * c - lx * sn) / 65536;
		w.xs    = SLOPE_W'(gxs);
		w.ys    = SLOPE_W'(gys);
		w.x_off = OFS_W'(gx - gxs * dz / 65536);
		w.y_off = OFS_W'(gy - gys * dz / 65536);
		return w;
	endfunction

	// Read word, either of a cell already hit or of a random address.
	function automatic track_word_t read_word(input bit from_hits);
		track_word_t w;
		int cell_idx;
		w      = random_word();
		w.func = 1'b1;
		if (from_hits && hit_cells.size() != 0) begin
			cell_idx = hit_cells[$urandom_range(hit_cells.size() - 1)];
			w.rx = XB_W'(cell_idx / (Y_BINS * SLOPE_BINS));
			w.ry = YB_W'((cell_idx / SLOPE_BINS) % Y_BINS);
			w.rs = SB_W'(cell_idx % SLOPE_BINS);
		end
		return w;
	endfunction

	function automatic track_word_t track_at(input longint xo, input longint yo,
	                                         input longint xs, input longint ys);
		track_word_t w;
		w        = '0;
		w.region = TRACK_REGION;
		w.pkg    = sel_package;
		w.x_off  = OFS_W'(xo);
		w.y_off  = OFS_W'(yo);
		w.xs     = SLOPE_W'(xs);
		w.ys     = SLOPE_W'(ys);
		return w;
	endfunction

	function automatic track_word_t read_at(input int rx, input int ry, input int rs);
		track_word_t w;
		w      = '0;
		w.func = 1'b1;
		w.rx   = XB_W'(rx);
		w.ry   = YB_W'(ry);
		w.rs   = SB_W'(rs);
		return w;
	endfunction

	// Send one word: optional idle gap, then hold it until the block takes it.
	task automatic send_word(input track_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= w.func;
		x_offset       <= w.x_off;
		y_offset       <= w.y_off;
		x_slope        <= w.xs;
		y_slope        <= w.ys;
		region         <= w.region;
		package_req    <= w.pkg;
		read_x_bin     <= w.rx;
		read_y_bin     <= w.ry;
		read_slope_bin <= w.rs;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		expected_results.push_back(project_and_bin(w));
		n_words++;
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input bit [CFG_DAT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Write all three registers while the block is idle and mirror them.
	task automatic set_config(input bit [PKG_W-1:0] pkg, input bit [OCT_W-1:0] oct,
	                          input bit [DIST_W-1:0] dz);
		put_reg(CFG_PACKAGE, CFG_DAT_W'(pkg));
		put_reg(CFG_OCTANT, CFG_DAT_W'(oct));
		put_reg(CFG_PLANE, CFG_DAT_W'(dz));
		cfg_we      <= 1'b0;
		sel_package = pkg;
		sel_octant  = oct;
		plane_dz    = dz;
		n_settings++;
	endtask

	function automatic void check_field(input string name, input bit [CNT_W-1:0] want,
	                                    input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	// Compare one result word with the oldest expectation.
	task automatic check_result();
		hit_result_t e;
		if (expected_results.size() == 0) begin
			$error("result word arrived with no expectation waiting");
			n_errors++;
		end else begin
			e = expected_results.pop_front();
			check_field("accepted", CNT_W'(e.accepted), CNT_W'(accepted));
			check_field("in_range", CNT_W'(e.in_range), CNT_W'(in_range));
			check_field("x_bin", CNT_W'(e.xb), CNT_W'(x_bin));
			check_field("y_bin", CNT_W'(e.yb), CNT_W'(y_bin));
			check_field("slope_bin", CNT_W'(e.sb), CNT_W'(slope_bin));
			check_field("bin_count", e.cnt, bin_count);
			check_field("tracks_used", e.used, tracks_used);
			check_field("off_fiducial", e.outside, off_fiducial);
		end
	endtask

	// Result side: check each result word that is taken and stall at random.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
				check_result();
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// The histogram must read back empty after reset, at valid and invalid addresses.
	task automatic test_cleared_histogram();
		send_word(read_at(0, 0, 0));
		send_word(read_at(X_BINS - 1, Y_BINS - 1, SLOPE_BINS - 1));
		send_word(read_at(15, 31, 15));
		send_word(read_at(X_BINS - 1, Y_BINS, 0));
		send_word(read_at(0, 0, SLOPE_BINS));
		drain_results();
	endtask

	// Bin edges, repeated hits on one bin, rejected tracks and field extremes.
	task automatic test_track_edges();
		track_word_t w;
		send_word(track_at(335 * 1024, 0, 26214, 0));
		send_word(track_at(335 * 1024, 0, 26214, 0));
		send_word(read_at(7, 10, 5));
		// Just below the low x edge truncates into bin 0.
		send_word(track_at(327679, 0, 26214, 0));
		// Exactly on the high x edge is off fiducial.
		send_word(track_at(350 * 1024, 0, 26214, 0));
		send_word(track_at(335 * 1024, 0, 26214, 13107));
		w = track_at(335 * 1024, 0, 26214, 0);
		w.region = 3'd2;
		send_word(w);
		w = track_at(335 * 1024, 0, 26214, 0);
		w.pkg = 3'd2;
		send_word(w);
		send_word(track_at(1048575, -1048576, 65535, -65536));
		send_word(track_at(-1048576, 1048575, -65536, 65535));
		drain_results();
	endtask

	// Register values outside the nominal ranges and the largest plane distance.
	task automatic test_register_corners();
		set_config(3'd0, 4'd0, 20'hFFFFF);
		send_word(aimed_track());
		send_word(track_at(1048575, 1048575, 65535, 65535));
		send_word(track_at(0, 0, 0, 0));
		drain_results();
		set_config(3'd7, 4'd15, 20'd0);
		send_word(aimed_track());
		send_word(aimed_track());
		send_word(track_at(-1048576, -1048576, -65536, -65536));
		send_word(read_word(1'b1));
		drain_results();
	endtask

	// One setting: mostly aimed tracks, with repeats of the latest track, reads, near misses
	// and noise mixed in.
	task automatic run_random_phase(input bit [PKG_W-1:0] pkg, input bit [OCT_W-1:0] oct,
	                                input bit [DIST_W-1:0] dz, input int count);
		track_word_t w, last;
		int roll;
		set_config(pkg, oct, dz);
		last = aimed_track();
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 10)
				w = last;
			else if (roll < 60)
				w = aimed_track();
			else if (roll < 70)
				w = read_word(1'b1);
			else if (roll < 76)
				w = read_word(1'b0);
			else if (roll < 84) begin
				w = aimed_track();
				if (roll[0])
					w.pkg = w.pkg ^ PKG_W'($urandom_range(7, 1));
				else
					w.region = w.region ^ REGION_W'($urandom_range(7, 1));
			end else
				w = random_word();
			if (roll < 60)
				last = w;
			send_word(w);
		end
		drain_results();
	endtask

	// Random traffic across the octants and several plane distances.
	task automatic test_random_traffic();
		run_random_phase(3'd1, 4'd1, 20'd0, 128);
		run_random_phase(3'd2, 4'd2, 20'd51200, 128);
		// A stretch with neither side idling.
		idle_pct = 0;
		run_random_phase(3'd3, 4'd3, 20'd204800, 128);
		idle_pct = 30;
		run_random_phase(3'd4, 4'd4, 20'd0, 128);
		run_random_phase(3'd1, 4'd5, 20'd102400, 128);
		run_random_phase(3'd2, 4'd6, 20'd10240, 128);
		run_random_phase(3'd3, 4'd7, 20'd307200, 128);
		run_random_phase(3'd4, 4'd8, 20'd0, 128);
		run_random_phase(3'd5, 4'd9, 20'd1024, 128);
	endtask

	// Test sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_histogram();
		test_track_edges();
		test_register_corners();
		test_random_traffic();
		repeat (20) @(posedge clk);
		$display("Sent %0d words under %0d register settings: %0d bin reads, %0d tracks kept.",
		         n_words, n_settings, n_reads, n_kept);
		$display("Of the kept tracks %0d were binned and %0d fell off fiducial.",
		         n_binned, n_off);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/tphh_pkg.sv
rtl/tphh_front.sv
rtl/tphh_queue.sv
rtl/tphh_back.sv
rtl/track_projection_hit_histogram_top.sv
tb/track_projection_hit_histogram_top_tb.sv
